>>> rtl/core/ray_box_slab_test_macros.svh
// ----------------------------------------------------------------------------
// Ray box slab test assertion macros
// Concurrent assertion helpers used by the top RTL file of the slab test.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define RBST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RBST_ASSERT_SAME(lbl, ante, cons, msg)
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/rbst_pkg.sv
// ----------------------------------------------------------------------------
// Ray box slab test package
// Register indexes and the control type shared by the slab test modules.
// ----------------------------------------------------------------------------
package rbst_pkg;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HEADING_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEADING_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HEADING_Z = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_NEAR      = 3'd6;

	// Load enables of the per-axis pipeline stages.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
		logic en5;
	} axis_ctl_t;

endpackage

>>> rtl/core/rbst_recip.sv
// ----------------------------------------------------------------------------
// Reciprocal unit
// Restoring divider that forms 2^(2*FRAC_BITS) / |heading| one quotient bit
// per cycle, then saturates it to the coordinate range.
// ----------------------------------------------------------------------------
module rbst_recip import rbst_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter bit RESET_ONE   = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COORD_WIDTH-1:0] heading,
	output logic                   busy,
	output logic [COORD_WIDTH-1:0] inv_mag,
	output logic                   inv_neg
);

	localparam int QW  = 2 * FRAC_BITS + 1;
	localparam int MW  = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;
	localparam int CNW = $clog2(QW + 1);
	localparam logic [MW-1:0] SB_W  = MW'(1) << (COORD_WIDTH - 1);
	localparam logic [MW-1:0] ONE_W = MW'(1) << FRAC_BITS;
	localparam logic [COORD_WIDTH-1:0] MAX_MAG = COORD_WIDTH'(SB_W - MW'(1));
	localparam logic [COORD_WIDTH-1:0] ONE_MAG =
		(ONE_W >= SB_W) ? MAX_MAG : ONE_W[COORD_WIDTH-1:0];
	localparam logic [COORD_WIDTH-1:0] RST_MAG = RESET_ONE ? ONE_MAG : MAX_MAG;

	logic                   busy_q;
	logic [CNW-1:0]         count_q;
	logic [COORD_WIDTH-1:0] rem_q;
	logic [COORD_WIDTH-1:0] dmag_q;
	logic                   neg_q;
	logic [QW-1:0]          quo_q;
	logic [COORD_WIDTH-1:0] inv_mag_q;
	logic                   inv_neg_q;

	logic [COORD_WIDTH-1:0] start_mag;
	logic [COORD_WIDTH-1:0] trial;
	logic                   ge;
	logic [MW-1:0]          quo_ext;

	// Magnitude of the new divisor; the most negative value fits unsigned.
	assign start_mag = heading[COORD_WIDTH-1] ? (~heading + COORD_WIDTH'(1)) : heading;

	// One restoring step: only the top numerator bit is set.
	assign trial = {rem_q[COORD_WIDTH-2:0], (count_q == CNW'(QW))};
	assign ge    = (trial >= dmag_q);
	assign quo_ext = MW'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			count_q   <= '0;
			inv_mag_q <= RST_MAG;
			inv_neg_q <= 1'b0;
		end else if (start) begin
			if (heading == '0) begin
				busy_q    <= 1'b0;
				inv_mag_q <= MAX_MAG;
				inv_neg_q <= 1'b0;
			end else begin
				busy_q  <= 1'b1;
				count_q <= CNW'(QW);
			end
		end else if (busy_q) begin
			if (count_q == '0) begin
				// Saturate the quotient to the signed coordinate range.
				busy_q    <= 1'b0;
				inv_neg_q <= neg_q;
				if (quo_ext >= SB_W) begin
					inv_mag_q <= neg_q ? SB_W[COORD_WIDTH-1:0] : MAX_MAG;
				end else begin
					inv_mag_q <= quo_ext[COORD_WIDTH-1:0];
				end
			end else begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	// Datapath of the divider needs no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			dmag_q <= start_mag;
			neg_q  <= heading[COORD_WIDTH-1];
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q && (count_q != '0)) begin
			rem_q <= ge ? (trial - dmag_q) : trial;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy    = busy_q;
	assign inv_mag = inv_mag_q;
	assign inv_neg = inv_neg_q;

endmodule

>>> rtl/core/rbst_axis.sv
// ----------------------------------------------------------------------------
// Slab axis pipeline
// Five stages that turn one axis's box bounds into the ordered pair of
// ray parameters at which the ray crosses the two slab planes.
// ----------------------------------------------------------------------------
module rbst_axis import rbst_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter bit RESET_ONE   = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  axis_ctl_t                     ctl,
	input  logic                          heading_we,
	input  logic        [COORD_WIDTH-1:0] heading,
	input  logic signed [COORD_WIDTH-1:0] origin,
	input  logic signed [COORD_WIDTH-1:0] box_lo,
	input  logic signed [COORD_WIDTH-1:0] box_hi,
	output logic                          busy,
	output logic signed [COORD_WIDTH-1:0] t_near,
	output logic signed [COORD_WIDTH-1:0] t_far
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = DW + COORD_WIDTH;
	localparam int XW = PW + COORD_WIDTH;
	localparam logic [XW-1:0] SB_X  = XW'(1) << (COORD_WIDTH - 1);
	localparam logic signed [COORD_WIDTH-1:0] T_MAX = COORD_WIDTH'(SB_X - XW'(1));
	localparam logic signed [COORD_WIDTH-1:0] T_MIN = SB_X[COORD_WIDTH-1:0];

	logic [COORD_WIDTH-1:0] inv_mag;
	logic                   inv_neg;

	logic signed [DW-1:0] d0_s1, d1_s1;
	logic [DW-1:0]        m0_s2, m1_s2;
	logic                 n0_s2, n1_s2;
	logic [PW-1:0]        p0_s3, p1_s3;
	logic                 n0_s3, n1_s3;
	logic signed [COORD_WIDTH-1:0] t0_s4, t1_s4;
	logic signed [COORD_WIDTH-1:0] a_s5, b_s5;

	logic [XW-1:0] q0, q1;
	logic signed [COORD_WIDTH-1:0] t0, t1;

	// Reciprocal of the heading component, refreshed after each write.
	rbst_recip #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.RESET_ONE   (RESET_ONE)
	) u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (heading_we),
		.heading (heading),
		.busy    (busy),
		.inv_mag (inv_mag),
		.inv_neg (inv_neg)
	);

	// Scaled magnitude with truncation toward zero, then saturation.
	function automatic logic signed [COORD_WIDTH-1:0] sat_t(input logic [XW-1:0] q,
		input logic neg);
		logic signed [COORD_WIDTH-1:0] r;
		if (q == '0) begin
			r = '0;
		end else if (!neg) begin
			r = (q >= SB_X) ? T_MAX : q[COORD_WIDTH-1:0];
		end else begin
			r = (q >= SB_X) ? T_MIN : (~q[COORD_WIDTH-1:0] + COORD_WIDTH'(1));
		end
		return r;
	endfunction

	assign q0 = XW'(p0_s3) >> FRAC_BITS;
	assign q1 = XW'(p1_s3) >> FRAC_BITS;
	assign t0 = sat_t(q0, n0_s3);
	assign t1 = sat_t(q1, n1_s3);

	always_ff @(posedge clk) begin
		// Stage 1: distance from the origin to both planes, one bit wider.
		if (ctl.en1) begin
			d0_s1 <= DW'(box_lo) - DW'(origin);
			d1_s1 <= DW'(box_hi) - DW'(origin);
		end
		// Stage 2: split into sign and magnitude.
		if (ctl.en2) begin
			n0_s2 <= d0_s1[DW-1];
			n1_s2 <= d1_s1[DW-1];
			m0_s2 <= d0_s1[DW-1] ? DW'(-d0_s1) : DW'(d0_s1);
			m1_s2 <= d1_s1[DW-1] ? DW'(-d1_s1) : DW'(d1_s1);
		end
		// Stage 3: multiply magnitudes by the reciprocal.
		if (ctl.en3) begin
			p0_s3 <= PW'(m0_s2) * PW'(inv_mag);
			p1_s3 <= PW'(m1_s2) * PW'(inv_mag);
			n0_s3 <= n0_s2 ^ inv_neg;
			n1_s3 <= n1_s2 ^ inv_neg;
		end
		// Stage 4: drop the fraction and saturate.
		if (ctl.en4) begin
			t0_s4 <= t0;
			t1_s4 <= t1;
		end
		// Stage 5: order the pair; equal values count as swapped.
		if (ctl.en5) begin
			a_s5 <= (t0_s4 < t1_s4) ? t0_s4 : t1_s4;
			b_s5 <= (t0_s4 < t1_s4) ? t1_s4 : t0_s4;
		end
	end

	assign t_near = a_s5;
	assign t_far  = b_s5;

endmodule

>>> rtl/core/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// Ray box slab test
// Tests one axis-aligned box per request against the ray held in the
// configuration registers.
// ----------------------------------------------------------------------------
// Usage: write the ray origin, heading and near limit through the plain
// write port (cfg_we, cfg_index, cfg_data) while the block is idle. Each
// input request carries the six box bounds and the far limit, and is taken
// when in_valid is high and in_stall is low. Each request gives exactly one
// result, box_hit, taken when out_valid is high and out_stall is low.
// A request's result moves through stages 1 to 7 and is shown from the
// stage-7 registers; the seven-stage pipeline takes a new request every
// cycle while in_stall is low.
// After a nonzero heading write that axis's serial divider rebuilds the
// reciprocal, one quotient bit per cycle, and in_stall stays high while
// the divider is busy.
// Reset restores the default ray and empties the pipeline; no clearing
// pass is needed. When the receiver stalls, the result holds and requests
// behind it close up the gaps in the pipeline before in_stall rises.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_macros.svh"

module ray_box_slab_test import rbst_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] box_lo_x,
	input  logic signed [COORD_WIDTH-1:0] box_hi_x,
	input  logic signed [COORD_WIDTH-1:0] box_lo_y,
	input  logic signed [COORD_WIDTH-1:0] box_hi_y,
	input  logic signed [COORD_WIDTH-1:0] box_lo_z,
	input  logic signed [COORD_WIDTH-1:0] box_hi_z,
	input  logic signed [COORD_WIDTH-1:0] far_limit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          box_hit
);

	localparam int NSTG = 7;
	localparam logic [COORD_WIDTH-1:0] NEAR_RST = COORD_WIDTH'(66);

	logic signed [COORD_WIDTH-1:0] origin_x_q, origin_y_q, origin_z_q, near_q;
	logic [NSTG:1] vld_q;
	logic [NSTG:1] ld;
	logic          busy_x, busy_y, busy_z, busy;
	axis_ctl_t     ctl;

	logic signed [COORD_WIDTH-1:0] ax, bx, ay, by, az, bz;
	logic signed [COORD_WIDTH-1:0] far_s1, far_s2, far_s3, far_s4, far_s5;
	logic signed [COORD_WIDTH-1:0] m1_s6, m2_s6, n1_s6, n2_s6;
	logic signed [COORD_WIDTH-1:0] lo_t, hi_t;
	logic                          hit_s7;

	// Configuration registers other than the headings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			near_q     <= NEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				REG_NEAR:     near_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it moves on.
	always_comb begin
		ld[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign busy     = busy_x || busy_y || busy_z;
	assign in_stall = !ld[1] || busy;
	assign ctl      = '{en1: ld[1], en2: ld[2], en3: ld[3], en4: ld[4], en5: ld[5]};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= in_valid && !in_stall;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .RESET_ONE(1'b1)) u_axis_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.heading_we (cfg_we && (cfg_index == REG_HEADING_X)),
		.heading    (cfg_data),
		.origin     (origin_x_q),
		.box_lo     (box_lo_x),
		.box_hi     (box_hi_x),
		.busy       (busy_x),
		.t_near     (ax),
		.t_far      (bx)
	);

	rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .RESET_ONE(1'b0)) u_axis_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.heading_we (cfg_we && (cfg_index == REG_HEADING_Y)),
		.heading    (cfg_data),
		.origin     (origin_y_q),
		.box_lo     (box_lo_y),
		.box_hi     (box_hi_y),
		.busy       (busy_y),
		.t_near     (ay),
		.t_far      (by)
	);

	rbst_axis #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .RESET_ONE(1'b0)) u_axis_z (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.heading_we (cfg_we && (cfg_index == REG_HEADING_Z)),
		.heading    (cfg_data),
		.origin     (origin_z_q),
		.box_lo     (box_lo_z),
		.box_hi     (box_hi_z),
		.busy       (busy_z),
		.t_near     (az),
		.t_far      (bz)
	);

	// Narrowing the interval over all axes at once: the near end only rises
	// and the far end only falls, so the final pair decides the result.
	assign lo_t = (m1_s6 > m2_s6) ? m1_s6 : m2_s6;
	assign hi_t = (n1_s6 < n2_s6) ? n1_s6 : n2_s6;

	always_ff @(posedge clk) begin
		// The far limit rides along with the axis stages.
		if (ld[1]) far_s1 <= far_limit;
		if (ld[2]) far_s2 <= far_s1;
		if (ld[3]) far_s3 <= far_s2;
		if (ld[4]) far_s4 <= far_s3;
		if (ld[5]) far_s5 <= far_s4;
		// Stage 6: first level of the max and min trees.
		if (ld[6]) begin
			m1_s6 <= (ax > near_q) ? ax : near_q;
			m2_s6 <= (ay > az) ? ay : az;
			n1_s6 <= (bx < far_s5) ? bx : far_s5;
			n2_s6 <= (by < bz) ? by : bz;
		end
		// Stage 7: final interval and the open test.
		if (ld[7]) begin
			hit_s7 <= (hi_t > lo_t);
		end
	end

	assign out_valid = vld_q[NSTG];
	assign box_hit   = hit_s7;

	`RBST_ASSERT_SAME(a_busy_stalls, busy, in_stall, "request taken while reciprocal busy")
	`RBST_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, vld_q[1], "accepted request lost")
	`RBST_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !vld_q[NSTG-1], !out_valid,
		"result repeated after delivery")

endmodule
